// ----- src/assert_macros.svh -----
// Assertion macros for the checker file slfp_chk.sv.
// Each macro expands to one labeled concurrent assertion clocked on clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASRT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASRT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- src/slfp_pkg.sv -----
// Package for the STX/length/checksum frame parser: types, codes and size constants.
// No dependencies.
`timescale 1ns / 1ps

package slfp_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int INDEX_REACH = 1024;
  localparam int IDX_W       = 10;
  localparam int LIM_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  // Cap on the length limit: payload parameter and reach of the index.
  localparam int LIMIT_CAP_I = (MAX_PAYLOAD < INDEX_REACH) ? MAX_PAYLOAD : INDEX_REACH;
  localparam logic [LIM_W-1:0] LIMIT_CAP = LIM_W'(LIMIT_CAP_I);

  localparam logic [15:0] CNT_MAX = 16'hffff;

  localparam logic [7:0]       START_RST  = 8'h02;
  localparam logic [LIM_W-1:0] MAXLEN_RST = LIM_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SUM_HI  = 3'd4,
    PH_SUM_LO  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_SUM_ERR  = 2'd2,
    ST_LEN_ERR  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]       start_byte;
    logic [LIM_W-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic             data_valid;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] data_index;
    logic [15:0]      frame_length;
    logic [15:0]      good_frames;
    logic [15:0]      bad_frames;
  } res_t;

endpackage

// ----- src/stx_length_sum_frame_parser_core.sv -----
// Top level of the STX/length/payload/checksum frame parser.
// Depends on slfp_pkg and slfp_parse.
`timescale 1ns / 1ps

//  channel | ports                          | direction
//  --------+--------------------------------+-----------------------------
//  in      | in_valid, in_stall, in_rx_byte | one received byte per word
//  out     | out_valid, out_stall, out_*    | one status word per byte
//  cfg     | cfg_we, cfg_index, cfg_data    | register writes, no read-back
//
//  One word per cycle sustained while out_stall is low; an accepted byte is held in
//  the input register, then its result is held in the result register behind out_valid.
//  The input register and the result register form a two-stage pipe: a word
//  moves into the result register as the parser state updates in the same edge.
//  An output stall holds the result and backs up into in_stall only when the
//  input register is also full.
//  Reset (rst_n low, synchronous) empties both stages, clears the parser and
//  restores start_byte = 2 and max_length = 1024.

module stx_length_sum_frame_parser_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic                                out_data_valid,
  output logic [7:0]                          out_data_byte,
  output logic [slfp_pkg::IDX_W-1:0]          out_data_index,
  output logic [15:0]                         out_frame_length,
  output logic [15:0]                         out_good_frames,
  output logic [15:0]                         out_bad_frames,
  input  logic                                cfg_we,
  input  logic [slfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  slfp_pkg::cfg_t cfg_r;
  logic           s1_valid_r, s1_valid_nxt;
  logic [7:0]     s1_byte_r;
  logic           out_valid_r, out_valid_nxt;
  slfp_pkg::res_t res_r;
  slfp_pkg::res_t step_res;
  logic           advance;
  logic           in_take;

  // Stage 1 moves on whenever the result register is free or being drained.
  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= slfp_pkg::START_RST;
      cfg_r.max_length <= slfp_pkg::MAXLEN_RST;
    end else if (cfg_we) begin
      unique case (slfp_pkg::cfg_idx_t'(cfg_index))
        slfp_pkg::CFG_START_BYTE: cfg_r.start_byte <= cfg_data[7:0];
        slfp_pkg::CFG_MAX_LENGTH: cfg_r.max_length <= cfg_data[slfp_pkg::LIM_W-1:0];
      endcase
    end
  end

  slfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (s1_byte_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  // Pipe valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take)
      s1_byte_r <= in_rx_byte;
    if (advance)
      res_r <= step_res;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_data_valid   = res_r.data_valid;
  assign out_data_byte    = res_r.data_byte;
  assign out_data_index   = res_r.data_index;
  assign out_frame_length = res_r.frame_length;
  assign out_good_frames  = res_r.good_frames;
  assign out_bad_frames   = res_r.bad_frames;

endmodule

// ----- src/slfp_parse.sv -----
// Deframing state machine with length, checksum and frame counters.
// Depends on slfp_pkg.
`timescale 1ns / 1ps

module slfp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          rx_byte,
  input  slfp_pkg::cfg_t      cfg,
  output slfp_pkg::res_t      res
);

  slfp_pkg::phase_t              phase_r, phase_nxt;
  logic [7:0]                    len_hi_r, len_hi_nxt;
  logic [15:0]                   len_r, len_nxt;
  logic [slfp_pkg::IDX_W-1:0]    pos_r, pos_nxt;
  logic [15:0]                   sum_r, sum_nxt;
  logic [7:0]                    sum_hi_r, sum_hi_nxt;
  logic [15:0]                   good_r, good_nxt;
  logic [15:0]                   bad_r, bad_nxt;

  logic [slfp_pkg::LIM_W-1:0]    limit;
  logic [15:0]                   len_rx;
  logic [15:0]                   sum_add;
  logic [slfp_pkg::IDX_W:0]      pos_inc;
  logic                          last_payload;
  logic                          sum_bad;
  logic                          is_start;

  assign limit   = (cfg.max_length > slfp_pkg::LIMIT_CAP) ? slfp_pkg::LIMIT_CAP
                                                          : cfg.max_length;
  assign len_rx  = {len_hi_r, rx_byte};
  assign sum_add = 16'(sum_r + {8'h00, rx_byte});
  assign pos_inc = {1'b0, pos_r} + (slfp_pkg::IDX_W+1)'(1);
  assign last_payload = {5'd0, pos_inc} >= len_r;
  assign sum_bad  = sum_r != {sum_hi_r, rx_byte};
  assign is_start = rx_byte == cfg.start_byte;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step_en) begin
      unique case (phase_r)
        slfp_pkg::PH_LEN_HI: phase_nxt = slfp_pkg::PH_LEN_LO;
        slfp_pkg::PH_LEN_LO: begin
          if (len_rx == 16'd0)
            phase_nxt = slfp_pkg::PH_SUM_HI;
          else if (len_rx > {5'd0, limit})
            phase_nxt = slfp_pkg::PH_IDLE;
          else
            phase_nxt = slfp_pkg::PH_PAYLOAD;
        end
        slfp_pkg::PH_PAYLOAD:
          phase_nxt = last_payload ? slfp_pkg::PH_SUM_HI : slfp_pkg::PH_PAYLOAD;
        slfp_pkg::PH_SUM_HI: phase_nxt = slfp_pkg::PH_SUM_LO;
        slfp_pkg::PH_SUM_LO:
          phase_nxt = (sum_bad && is_start) ? slfp_pkg::PH_LEN_HI : slfp_pkg::PH_IDLE;
        default:
          phase_nxt = is_start ? slfp_pkg::PH_LEN_HI : slfp_pkg::PH_IDLE;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    len_hi_nxt = len_hi_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    sum_hi_nxt = sum_hi_r;
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    res.status     = slfp_pkg::ST_OK;
    res.data_valid = 1'b0;
    res.data_byte  = 8'h00;
    res.data_index = '0;
    unique case (phase_r)
      slfp_pkg::PH_LEN_HI: begin
        len_hi_nxt = rx_byte;
        sum_nxt    = sum_add;
      end
      slfp_pkg::PH_LEN_LO: begin
        sum_nxt = sum_add;
        len_nxt = len_rx;
        pos_nxt = '0;
        if (len_rx != 16'd0 && len_rx > {5'd0, limit}) begin
          res.status = slfp_pkg::ST_LEN_ERR;
          bad_nxt    = (bad_r == slfp_pkg::CNT_MAX) ? bad_r : bad_r + 16'd1;
        end
      end
      slfp_pkg::PH_PAYLOAD: begin
        sum_nxt        = sum_add;
        res.data_valid = 1'b1;
        res.data_byte  = rx_byte;
        res.data_index = pos_r;
        if (!last_payload)
          pos_nxt = pos_inc[slfp_pkg::IDX_W-1:0];
      end
      slfp_pkg::PH_SUM_HI: sum_hi_nxt = rx_byte;
      slfp_pkg::PH_SUM_LO: begin
        if (sum_bad) begin
          res.status = slfp_pkg::ST_SUM_ERR;
          bad_nxt    = (bad_r == slfp_pkg::CNT_MAX) ? bad_r : bad_r + 16'd1;
          // final byte doubles as the start of the next frame
          if (is_start) begin
            len_nxt = 16'd0;
            sum_nxt = 16'd0;
            pos_nxt = '0;
          end
        end else begin
          res.status = slfp_pkg::ST_COMPLETE;
          good_nxt   = (good_r == slfp_pkg::CNT_MAX) ? good_r : good_r + 16'd1;
        end
      end
      default: begin
        if (is_start) begin
          sum_nxt = 16'd0;
          pos_nxt = '0;
        end
      end
    endcase
    res.frame_length = len_nxt;
    res.good_frames  = good_nxt;
    res.bad_frames   = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= slfp_pkg::PH_IDLE;
      len_hi_r <= 8'h00;
      len_r    <= 16'd0;
      pos_r    <= '0;
      sum_r    <= 16'd0;
      sum_hi_r <= 8'h00;
      good_r   <= 16'd0;
      bad_r    <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      if (step_en) begin
        len_hi_r <= len_hi_nxt;
        len_r    <= len_nxt;
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
        sum_hi_r <= sum_hi_nxt;
        good_r   <= good_nxt;
        bad_r    <= bad_nxt;
      end
    end
  end

endmodule

// ----- src/slfp_chk.sv -----
// Port-level checker for the frame parser top level, bound in below.
// Depends on slfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slfp_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_status,
  input logic                                out_data_valid,
  input logic [7:0]                          out_data_byte,
  input logic [slfp_pkg::IDX_W-1:0]          out_data_index,
  input logic [15:0]                         out_frame_length,
  input logic [15:0]                         out_good_frames,
  input logic [15:0]                         out_bad_frames
);

  // payload words carry no frame status
  `ASRT_IMP(a_data_ok, out_valid && out_data_valid, out_status == slfp_pkg::ST_OK)

  // payload index always falls inside the current length
  `ASRT_IMP(a_idx_in_len, out_valid && out_data_valid, {6'd0, out_data_index} < out_frame_length)

  // non-payload words zero their data fields
  `ASRT_IMP(a_data_zero, out_valid && !out_data_valid, out_data_byte == 8'h00 && out_data_index == '0)

  // stalled result holds
  `ASRT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_good_frames) && $stable(out_bad_frames))

  // input backs up only behind a stalled result
  `ASRT_IMP(a_in_stall, in_stall, out_valid && out_stall)

endmodule

bind stx_length_sum_frame_parser_core slfp_chk u_slfp_chk (.*);
